@@ hw/rtl/afd_pkg.sv @@
`timescale 1ns / 1ps

package afd_pkg;

	// Frame layout
	localparam int FRAME_LEN   = 13;
	localparam int POS_W       = $clog2(FRAME_LEN);
	localparam int POS_COUNTRY = 4;
	localparam int POS_LAST    = FRAME_LEN - 1;
	localparam int STORE_N     = POS_LAST - POS_COUNTRY;

	localparam logic [7:0] START_RESET = 8'hAA;

	// Field widths
	localparam int COUNTRY_W = 16;
	localparam int ANIMAL_W  = 40;
	localparam int UPPER_W   = 21;
	localparam int LOWER_W   = 20;

	// Split by one million: estimate from the top 20 bits of the number times
	// a 21-bit reciprocal, then correct the remainder by repeated subtraction
	localparam int                 EST_W       = 20;
	localparam logic [LOWER_W-1:0] DIGIT_SPLIT = 20'd1000000;
	localparam logic [UPPER_W-1:0] RECIP       = 21'd1099511;
	localparam int                 PROD_W      = EST_W + UPPER_W;
	localparam int                 REM_W       = 22;

	// Queue between collector and divider
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [COUNTRY_W-1:0] country;
		logic [ANIMAL_W-1:0]  animal;
		logic [7:0]           check;
		logic [7:0]           closing;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

@@ hw/rtl/afd_front.sv @@
`timescale 1ns / 1ps

module afd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	input  afd_pkg::q_status_t q_status,
	output logic               push,
	output afd_pkg::frame_t    push_frame
);
	import afd_pkg::*;

	logic [7:0]       start_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       data_q [STORE_N];
	logic             accept;
	logic             take;
	logic             last;

	// Hold input while the queue has no room for a finished frame
	assign in_stall  = q_status.full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;

	// Keep a byte if a frame is open or it opens one; drop it otherwise
	assign take = accept && ((pos_q != '0) || (rx_byte == start_q));
	assign last = take && (pos_q == POS_W'(POS_LAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
		end else if (cfg_valid && cfg_ready) begin
			start_q <= cfg_data;
		end
	end

	// Advance the byte position, wrap after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			pos_q <= last ? '0 : pos_q + 1'b1;
		end
	end

	// Store the bytes that feed the result
	always_ff @(posedge clk) begin
		for (int i = 0; i < STORE_N; i++) begin
			if (take && pos_q == POS_W'(POS_COUNTRY + i)) begin
				data_q[i] <= rx_byte;
			end
		end
	end

	// Build the frame record on the last byte
	assign push                = last;
	assign push_frame.country  = {data_q[0], data_q[1]};
	assign push_frame.animal   = {data_q[2], data_q[3], data_q[4], data_q[5], data_q[6]};
	assign push_frame.check    = data_q[7];
	assign push_frame.closing  = rx_byte;

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(POS_LAST))
		else $error("byte position beyond frame");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("frame pushed into full queue");
`endif

endmodule

@@ hw/rtl/afd_queue.sv @@
`timescale 1ns / 1ps

module afd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  afd_pkg::frame_t    push_frame,
	input  logic               pop,
	output afd_pkg::frame_t    pop_frame,
	output afd_pkg::q_status_t q_status
);
	import afd_pkg::*;

	frame_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_status.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_status.empty = (count_q == '0);
	assign pop_frame      = mem_q[rd_ptr_q];

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");
`endif

endmodule

@@ hw/rtl/afd_back.sv @@
`timescale 1ns / 1ps

module afd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  afd_pkg::q_status_t          q_status,
	input  afd_pkg::frame_t             pop_frame,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [afd_pkg::COUNTRY_W-1:0] country_value,
	output logic [afd_pkg::ANIMAL_W-1:0]  animal_number,
	output logic [afd_pkg::UPPER_W-1:0]   upper_digit_group,
	output logic [afd_pkg::LOWER_W-1:0]   lower_digit_group,
	output logic [7:0]                  check_byte,
	output logic [7:0]                  closing_byte
);
	import afd_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MUL1 = 3'd1;
	localparam logic [2:0] B_MUL2 = 3'd2;
	localparam logic [2:0] B_SUB  = 3'd3;
	localparam logic [2:0] B_FIX  = 3'd4;
	localparam logic [2:0] B_OUT  = 3'd5;

	logic [2:0]          state_q;
	frame_t              rec_q;
	logic [PROD_W-1:0]   prod1_q;
	logic [ANIMAL_W-1:0] prod2_q;
	logic [UPPER_W-1:0]  quo_q;
	logic [REM_W-1:0]    rem_q;
	logic                out_valid_q;
	logic                out_load;
	frame_t              out_rec_q;
	logic [UPPER_W-1:0]  out_quo_q;
	logic [LOWER_W-1:0]  out_rem_q;

	assign pop      = (state_q == B_IDLE) && !q_status.empty;
	assign out_load = (state_q == B_OUT) && (!out_valid_q || !out_stall);

	// Sequence one frame through estimate, back-multiply and correction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			unique case (state_q)
				B_IDLE: if (pop) state_q <= B_MUL1;
				B_MUL1: state_q <= B_MUL2;
				B_MUL2: state_q <= B_SUB;
				B_SUB:  state_q <= B_FIX;
				B_FIX:  if (rem_q < REM_W'(DIGIT_SPLIT)) state_q <= B_OUT;
				B_OUT:  if (out_load) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= pop_frame;
		end
		// quotient estimate from the top bits, never above the true quotient
		prod1_q <= PROD_W'(rec_q.animal[ANIMAL_W-1 -: EST_W]) * PROD_W'(RECIP);
		if (state_q == B_MUL2) begin
			quo_q   <= prod1_q[PROD_W-1 -: UPPER_W];
			prod2_q <= ANIMAL_W'(PROD_W'(prod1_q[PROD_W-1 -: UPPER_W]) * PROD_W'(DIGIT_SPLIT));
		end
		if (state_q == B_SUB) begin
			rem_q <= REM_W'(rec_q.animal - prod2_q);
		end
		// remainder is below four times the divisor: subtract until in range
		if (state_q == B_FIX && rem_q >= REM_W'(DIGIT_SPLIT)) begin
			rem_q <= rem_q - REM_W'(DIGIT_SPLIT);
			quo_q <= quo_q + 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rec_q <= rec_q;
			out_quo_q <= quo_q;
			out_rem_q <= LOWER_W'(rem_q);
		end
	end

	assign out_valid         = out_valid_q;
	assign country_value     = out_rec_q.country;
	assign animal_number     = out_rec_q.animal;
	assign upper_digit_group = out_quo_q;
	assign lower_digit_group = out_rem_q;
	assign check_byte        = out_rec_q.check;
	assign closing_byte      = out_rec_q.closing;

`ifndef SYNTHESIS
	a_fix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_FIX) |-> (rem_q < REM_W'(4 * 1000000)))
		else $error("remainder estimate out of range");
	a_out_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_OUT) |-> (rem_q < REM_W'(DIGIT_SPLIT)))
		else $error("remainder not reduced");
`endif

endmodule

@@ hw/rtl/animal_tag_frame_decoder.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_stall    | rx_byte
// out     | output    | out_valid / out_stall  | country_value, animal_number,
//         |           |                        | upper_digit_group, lower_digit_group,
//         |           |                        | check_byte, closing_byte
// cfg     | input     | cfg_valid / cfg_ready  | cfg_data (start byte)
//
// One byte is taken per cycle unless stalled; a frame of 13 bytes gives one result.
// In the divide-by-one-million unit a result passes the states MUL1, MUL2, SUB,
// FIX (repeated remainder correction) and OUT before it enters the output register.
// A two-entry frame queue sits between the byte collector and the divider;
// in_stall rises only while that queue is full.
// Reset is asynchronous; no clearing pass, cfg_ready is always high.

module animal_tag_frame_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [7:0]                    cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [afd_pkg::COUNTRY_W-1:0] country_value,
	output logic [afd_pkg::ANIMAL_W-1:0]  animal_number,
	output logic [afd_pkg::UPPER_W-1:0]   upper_digit_group,
	output logic [afd_pkg::LOWER_W-1:0]   lower_digit_group,
	output logic [7:0]                    check_byte,
	output logic [7:0]                    closing_byte
);
	import afd_pkg::*;

	q_status_t q_status;
	logic      push;
	logic      pop;
	frame_t    push_frame;
	frame_t    pop_frame;

	afd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.q_status   (q_status),
		.push       (push),
		.push_frame (push_frame)
	);

	afd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.pop_frame  (pop_frame),
		.q_status   (q_status)
	);

	afd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_status          (q_status),
		.pop_frame         (pop_frame),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.country_value     (country_value),
		.animal_number     (animal_number),
		.upper_digit_group (upper_digit_group),
		.lower_digit_group (lower_digit_group),
		.check_byte        (check_byte),
		.closing_byte      (closing_byte)
	);

endmodule
